FILE: design/vhd_pkg.sv
`timescale 1ns / 1ps
package vhd_pkg;

    localparam int C_MAX_CONSTRAINT = 7;
    localparam int C_MAX_GENERATORS = 4;
    localparam int C_MAX_SYMBOLS    = 1024;

    localparam int C_SW = C_MAX_CONSTRAINT - 1;   // state index width
    localparam int C_NS = 1 << C_SW;              // trellis states
    localparam int C_MW = 13;                     // path metric width
    localparam logic [C_MW-1:0] C_METRIC_MAX = 13'd8191;

    // Configuration register indexes.
    localparam logic [2:0] C_REG_K      = 3'd0;
    localparam logic [2:0] C_REG_G      = 3'd1;
    localparam logic [2:0] C_REG_POLY_A = 3'd2;
    localparam logic [2:0] C_REG_POLY_B = 3'd3;
    localparam logic [2:0] C_REG_POLY_C = 3'd4;
    localparam logic [2:0] C_REG_POLY_D = 3'd5;

    typedef struct packed {
        logic signed [7:0] soft_value;
        logic              frame_end;
    } t_in_item;

    typedef struct packed {
        logic [63:0]     decoded_word;
        logic [6:0]      bit_count;
        logic            last_word;
        logic [C_MW-1:0] best_metric;
        logic            truncated;
    } t_result;

    typedef struct packed {
        logic [C_MW-1:0] metric;
        logic            reach;
        logic            dec;
    } t_acs_out;

endpackage

FILE: design/viterbi_hard_decoder_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                     Payload
// item      in         i_start high, o_busy low      i_item (soft_value, frame_end)
// result    out        o_valid, one cycle, no stall  o_result (word, count, flags)
// config    in         i_cfg_we                      i_cfg_idx, i_cfg_data
//
// An item that completes no symbol only adds its hard bit to the partial
// symbol. An item that completes a symbol runs the shared add-compare-select
// unit over the 2^(K-1) states, one state per cycle, followed by the pipeline
// and the survivor write. A frame end adds a best-state sweep, a traceback
// step per stored symbol and an output step per result word.
// Reset is synchronous; the first cycle after it clears the frame state.
// Results are shown for one cycle each and cannot be held off.
module viterbi_hard_decoder_core #(
    parameter int MAX_SYMBOLS = vhd_pkg::C_MAX_SYMBOLS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  vhd_pkg::t_in_item i_item,
    output logic              o_busy,
    output logic              o_valid,
    output vhd_pkg::t_result  o_result,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [6:0]        i_cfg_data
);
    import vhd_pkg::*;

    localparam int CW  = $clog2(MAX_SYMBOLS + 1);
    localparam int IW  = $clog2(MAX_SYMBOLS);
    localparam int WN  = (MAX_SYMBOLS + 63) / 64;
    localparam int WW  = (WN > 1) ? $clog2(WN) : 1;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_ACS   = 4'd2;
    localparam logic [3:0] S_SWR   = 4'd3;
    localparam logic [3:0] S_FIN   = 4'd4;
    localparam logic [3:0] S_BEST  = 4'd5;
    localparam logic [3:0] S_TB    = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;

    // Configuration registers.
    logic [2:0] r_cfg_k, r_cfg_g;
    logic [6:0] r_poly [4];

    logic [3:0]      r_state;
    logic [3:0]      r_symbits;
    logic [1:0]      r_bitpos;
    logic [CW-1:0]   r_count;
    logic            r_ovf;
    logic            r_end;
    logic [3:0]      r_sym;
    logic            r_cur;
    logic [C_NS-1:0] r_reach_cur, r_reach_nxt;
    logic [C_SW:0]   r_n;
    logic            r_p_v;
    logic [C_SW-1:0] r_p_n;
    logic            r_pr0, r_pr1;
    logic [63:0]     r_dec;
    logic            r_found;
    logic [C_MW-1:0] r_bm;
    logic [C_SW-1:0] r_best;
    logic [CW-1:0]   r_dlen;
    logic [CW-1:0]   r_t;
    logic            r_ph;
    logic [63:0]     r_acc;
    logic [WW-1:0]   r_w;
    logic [CW-1:0]   r_nwords;
    logic            r_valid;
    t_result         r_result;

    // Path metrics: two banks, one being read while the other is written.
    logic [C_MW-1:0] r_pm [2*C_NS];
    logic [C_MW-1:0] r_rd0, r_rd1;
    logic [C_SW:0]   ra0, ra1, wa;
    logic            pm_we;
    logic [C_MW-1:0] pm_wd;

    logic [63:0]     r_surv [MAX_SYMBOLS];
    logic [63:0]     r_sv;
    logic [63:0]     r_wm [WN];
    logic [63:0]     r_wrd;

    logic [2:0]      k_eff, g_eff;
    logic [C_SW:0]   ns;
    logic [C_SW-1:0] half;
    logic            hard;
    logic [3:0]      n_symbits;
    logic            sym_done;
    logic [C_SW-1:0] s0, s1;
    t_acs_out        acs;
    logic [IW-1:0]   tb_idx;
    logic            tb_hi;
    logic [63:0]     n_acc;
    logic [CW-1:0]   left;

    always_comb begin
        k_eff = r_cfg_k;
        if (k_eff < 3'd2) k_eff = 3'd2;
        if (k_eff > 3'(C_MAX_CONSTRAINT)) k_eff = 3'(C_MAX_CONSTRAINT);
        g_eff = r_cfg_g;
        if (g_eff < 3'd1) g_eff = 3'd1;
        if (g_eff > 3'(C_MAX_GENERATORS)) g_eff = 3'(C_MAX_GENERATORS);
    end

    assign ns        = (C_SW+1)'(1) << (k_eff - 3'd1);
    assign half      = ns[C_SW:1];
    assign hard      = i_item.soft_value > 8'sd0;
    assign n_symbits = r_symbits | (4'(hard) << r_bitpos);
    assign sym_done  = ({1'b0, r_bitpos} + 3'd1) >= g_eff;
    assign s0        = r_n[C_SW:1];
    assign s1        = r_n[C_SW:1] | half;
    assign tb_idx    = IW'(r_t - CW'(1));
    assign tb_hi     = r_sv[r_best];
    assign n_acc     = r_acc | (64'((tb_idx < IW'(r_dlen)) && r_best[0]) << tb_idx[5:0]);
    assign left      = r_dlen - (CW'(r_w) << 6);

    vhd_acs u_acs (
        .i_state   (r_p_n),
        .i_ns      (ns),
        .i_num_gen (g_eff),
        .i_poly    (r_poly),
        .i_sym     (r_sym),
        .i_metric0 (r_rd0),
        .i_metric1 (r_rd1),
        .i_reach0  (r_pr0),
        .i_reach1  (r_pr1),
        .o_acs     (acs)
    );

    always_comb begin
        ra0   = {r_cur, (r_state == S_BEST) ? r_n[C_SW-1:0] : s0};
        ra1   = {r_cur, s1};
        pm_we = 1'b0;
        wa    = {r_cur, {C_SW{1'b0}}};
        pm_wd = '0;
        if (r_state == S_CLEAR) begin
            pm_we = 1'b1;
        end else if (r_state == S_ACS && r_p_v) begin
            pm_we = 1'b1;
            wa    = {~r_cur, r_p_n};
            pm_wd = acs.metric;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pm_we) r_pm[wa] <= pm_wd;
        r_rd0 <= r_pm[ra0];
        r_rd1 <= r_pm[ra1];
        if (r_state == S_SWR) r_surv[r_count[IW-1:0]] <= r_dec;
        r_sv <= r_surv[tb_idx];
        if (r_state == S_TB && r_ph && tb_idx[5:0] == 6'd0) r_wm[WW'(tb_idx >> 6)] <= n_acc;
        r_wrd <= r_wm[r_w];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_k <= 3'd7;
            r_cfg_g <= 3'd2;
            r_poly  <= '{7'h79, 7'h5B, 7'h00, 7'h00};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                C_REG_K:      r_cfg_k   <= i_cfg_data[2:0];
                C_REG_G:      r_cfg_g   <= i_cfg_data[2:0];
                C_REG_POLY_A: r_poly[0] <= i_cfg_data;
                C_REG_POLY_B: r_poly[1] <= i_cfg_data;
                C_REG_POLY_C: r_poly[2] <= i_cfg_data;
                C_REG_POLY_D: r_poly[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cur   <= 1'b0;
            r_p_v   <= 1'b0;
            r_valid <= 1'b0;
            r_end   <= 1'b0;
            r_count <= '0;
        end else begin
            r_valid <= 1'b0;
            r_p_v   <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    // Only state zero is reachable at the start of a frame.
                    r_symbits   <= '0;
                    r_bitpos    <= '0;
                    r_count     <= '0;
                    r_ovf       <= 1'b0;
                    r_end       <= 1'b0;
                    r_reach_cur <= C_NS'(1);
                    r_state     <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_end <= i_item.frame_end;
                        if (sym_done) begin
                            r_symbits <= '0;
                            r_bitpos  <= '0;
                            if (r_count < CW'(MAX_SYMBOLS)) begin
                                // States beyond the current trellis size
                                // come out of this symbol unreachable.
                                r_sym       <= n_symbits;
                                r_n         <= '0;
                                r_dec       <= '0;
                                r_reach_nxt <= '0;
                                r_state     <= S_ACS;
                            end else begin
                                r_ovf <= 1'b1;
                                if (i_item.frame_end) r_state <= S_FIN;
                            end
                        end else begin
                            r_symbits <= n_symbits;
                            r_bitpos  <= r_bitpos + 2'd1;
                            if (i_item.frame_end) r_state <= S_FIN;
                        end
                    end
                end
                S_ACS: begin
                    // Issue the two predecessor reads for one state, and
                    // finish the state whose reads were issued the cycle before.
                    if (r_n < ns) begin
                        r_pr0 <= r_reach_cur[s0];
                        r_pr1 <= r_reach_cur[s1];
                        r_p_n <= r_n[C_SW-1:0];
                        r_p_v <= 1'b1;
                        r_n   <= r_n + (C_SW+1)'(1);
                    end
                    if (r_p_v) begin
                        r_reach_nxt[r_p_n] <= acs.reach;
                        r_dec[r_p_n]       <= acs.dec;
                        if ({1'b0, r_p_n} == ns - (C_SW+1)'(1)) r_state <= S_SWR;
                    end
                end
                S_SWR: begin
                    r_count     <= r_count + CW'(1);
                    r_cur       <= ~r_cur;
                    r_reach_cur <= r_reach_nxt;
                    r_state     <= r_end ? S_FIN : S_IDLE;
                end
                S_FIN: begin
                    r_found <= 1'b0;
                    r_n     <= '0;
                    r_acc   <= '0;
                    r_dlen  <= r_count - CW'(k_eff - 3'd1);
                    r_state <= (r_count <= CW'(k_eff - 3'd1)) ? S_CLEAR : S_BEST;
                end
                S_BEST: begin
                    if (r_n < ns) begin
                        r_p_n <= r_n[C_SW-1:0];
                        r_p_v <= 1'b1;
                        r_n   <= r_n + (C_SW+1)'(1);
                    end
                    if (r_p_v) begin
                        if (r_reach_cur[r_p_n] && (!r_found || r_rd0 < r_bm)) begin
                            r_bm    <= r_rd0;
                            r_best  <= r_p_n;
                            r_found <= 1'b1;
                        end
                        if ({1'b0, r_p_n} == ns - (C_SW+1)'(1)) begin
                            r_t      <= r_count;
                            r_ph     <= 1'b0;
                            r_nwords <= (r_dlen + CW'(63)) >> 6;
                            r_state  <= S_TB;
                        end
                    end
                end
                S_TB: begin
                    // One survivor word is read, then used, per symbol.
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_acc  <= (tb_idx[5:0] == 6'd0) ? 64'd0 : n_acc;
                        r_best <= (r_best >> 1) | (tb_hi ? half : '0);
                        r_t    <= r_t - CW'(1);
                        if (r_t == CW'(1)) begin
                            r_w     <= '0;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_valid                <= 1'b1;
                        r_result.decoded_word  <= r_wrd;
                        r_result.bit_count     <= (left > CW'(64)) ? 7'd64 : left[6:0];
                        r_result.last_word     <= (CW'(r_w) + CW'(1)) == r_nwords;
                        r_result.best_metric   <= r_bm;
                        r_result.truncated     <= r_ovf;
                        r_w                    <= r_w + WW'(1);
                        if ((CW'(r_w) + CW'(1)) == r_nwords) r_state <= S_CLEAR;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    assign o_busy   = r_state != S_IDLE;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // A result word only follows a cycle of the output sweep.
    a_valid_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(r_state) == S_OUT)
        else $error("result strobe outside output sweep");

    // The symbol store never holds more symbols than it has rows.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SYMBOLS))
        else $error("symbol count beyond store depth");

    // A new frame starts with state zero reachable.
    a_clear_reach: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |=> r_reach_cur[0])
        else $error("state zero not reachable after clear");

endmodule

FILE: design/vhd_acs.sv
`timescale 1ns / 1ps
module vhd_acs (
    input  logic [vhd_pkg::C_SW-1:0]   i_state,
    input  logic [vhd_pkg::C_SW:0]     i_ns,
    input  logic [2:0]                 i_num_gen,
    input  logic [6:0]                 i_poly [4],
    input  logic [3:0]                 i_sym,
    input  logic [vhd_pkg::C_MW-1:0]   i_metric0,
    input  logic [vhd_pkg::C_MW-1:0]   i_metric1,
    input  logic                       i_reach0,
    input  logic                       i_reach1,
    output vhd_pkg::t_acs_out          o_acs
);
    import vhd_pkg::*;

    logic [C_SW:0] reg0;
    logic [C_SW:0] reg1;
    logic [2:0]    dist0;
    logic [2:0]    dist1;
    logic [C_MW:0] sum0;
    logic [C_MW:0] sum1;
    logic [C_MW-1:0] cost0;
    logic [C_MW-1:0] cost1;

    // The encoder register seen from either predecessor: the low branch
    // holds the state itself, the high branch adds the oldest bit.
    assign reg0 = {1'b0, i_state};
    assign reg1 = {1'b0, i_state} | i_ns;

    always_comb begin
        dist0 = 3'd0;
        dist1 = 3'd0;
        for (int p = 0; p < 4; p++) begin
            if (3'(p) < i_num_gen) begin
                dist0 = dist0 + 3'((^(i_poly[p] & reg0)) ^ i_sym[p]);
                dist1 = dist1 + 3'((^(i_poly[p] & reg1)) ^ i_sym[p]);
            end
        end
        sum0  = {1'b0, i_metric0} + {{(C_MW-2){1'b0}}, dist0};
        sum1  = {1'b0, i_metric1} + {{(C_MW-2){1'b0}}, dist1};
        cost0 = sum0[C_MW] ? C_METRIC_MAX : sum0[C_MW-1:0];
        cost1 = sum1[C_MW] ? C_METRIC_MAX : sum1[C_MW-1:0];
        o_acs = '0;
        if (i_reach0 && (!i_reach1 || cost0 <= cost1)) begin
            o_acs.metric = cost0;
            o_acs.reach  = 1'b1;
        end else if (i_reach1) begin
            o_acs.metric = cost1;
            o_acs.reach  = 1'b1;
            o_acs.dec    = 1'b1;
        end
    end

endmodule

FILE: bench/viterbi_hard_decoder_checker.sv
`timescale 1ns / 1ps
module viterbi_hard_decoder_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  vhd_pkg::t_in_item i_item,
    input  logic              i_valid,
    input  vhd_pkg::t_result  i_result,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [6:0]        i_cfg_data,
    output int                o_fail_count,
    output int                o_pending
);
    import vhd_pkg::*;

    localparam int NSYM = C_MAX_SYMBOLS;

    logic [2:0] cfg_k, cfg_g;
    logic [6:0] polys [4];

    logic [3:0]      sym_acc;
    int              bit_pos;
    int              sym_cnt;
    logic            cut_flag;
    logic [C_MW-1:0] metric [C_NS];
    logic            reach  [C_NS];
    logic [C_NS-1:0] survivors [NSYM];

    t_result expected_words [$];

    assign o_pending = expected_words.size();

    function automatic int eff_k();
        int k;
        k = cfg_k;
        if (k < 2) k = 2;
        if (k > C_MAX_CONSTRAINT) k = C_MAX_CONSTRAINT;
        return k;
    endfunction

    function automatic int eff_g();
        int g;
        g = cfg_g;
        if (g < 1) g = 1;
        if (g > C_MAX_GENERATORS) g = C_MAX_GENERATORS;
        return g;
    endfunction

    task automatic clear_frame();
        sym_acc  = '0;
        bit_pos  = 0;
        sym_cnt  = 0;
        cut_flag = 1'b0;
        for (int n = 0; n < C_NS; n++) begin
            metric[n] = '0;
            reach[n]  = (n == 0);
        end
    endtask

    task automatic advance_trellis(logic [3:0] sym);
        int k, g, ns, half, hdist, cost, s, regv;
        logic [C_MW-1:0] nm [C_NS];
        logic            nr [C_NS];
        logic [C_NS-1:0] dec;
        k = eff_k();
        g = eff_g();
        ns = 1 << (k - 1);
        half = ns >> 1;
        dec = '0;
        for (int n = 0; n < C_NS; n++) begin
            nm[n] = '0;
            nr[n] = 1'b0;
        end
        for (int n = 0; n < ns; n++) begin
            for (int j = 0; j < 2; j++) begin
                s = (n >> 1) | (j ? half : 0);
                if (reach[s]) begin
                    regv = ((s << 1) | (n & 1)) & ((1 << k) - 1);
                    hdist = 0;
                    for (int p = 0; p < g; p++)
                        hdist += (^(polys[p] & regv[6:0])) ^ sym[p];
                    cost = metric[s] + hdist;
                    if (cost > C_METRIC_MAX) cost = C_METRIC_MAX;
                    if (!nr[n] || cost < nm[n]) begin
                        nm[n] = C_MW'(cost);
                        nr[n] = 1'b1;
                        dec[n] = (j != 0);
                    end
                end
            end
        end
        for (int n = 0; n < C_NS; n++) begin
            metric[n] = nm[n];
            reach[n]  = nr[n];
        end
        survivors[sym_cnt] = dec;
    endtask

    task automatic trace_frame();
        int k, ns, half, best, data_len, nwords, left, s;
        logic [C_MW-1:0] bm;
        logic found;
        logic [63:0] words [NSYM/64];
        t_result r;
        k = eff_k();
        if (sym_cnt <= k - 1) return;
        ns = 1 << (k - 1);
        half = ns >> 1;
        data_len = sym_cnt - (k - 1);
        best = 0;
        bm = '0;
        found = 1'b0;
        for (int i = 0; i < ns; i++) begin
            if (reach[i] && (!found || metric[i] < bm)) begin
                bm = metric[i];
                best = i;
                found = 1'b1;
            end
        end
        for (int w = 0; w < NSYM/64; w++) words[w] = '0;
        s = best;
        for (int t = sym_cnt - 1; t >= 0; t--) begin
            if (t < data_len && s[0]) words[t/64][t%64] = 1'b1;
            s = (s >> 1) | (survivors[t][s] ? half : 0);
        end
        nwords = (data_len + 63) / 64;
        for (int w = 0; w < nwords; w++) begin
            left = data_len - w * 64;
            r.decoded_word = words[w];
            r.bit_count    = (left > 64) ? 7'd64 : 7'(left);
            r.last_word    = (w + 1 == nwords);
            r.best_metric  = bm;
            r.truncated    = cut_flag;
            expected_words.push_back(r);
        end
    endtask

    task automatic take_item(t_in_item it);
        logic hard;
        hard = (it.soft_value > 0);
        sym_acc[bit_pos] = hard;
        if (bit_pos + 1 >= eff_g()) begin
            if (sym_cnt < NSYM) begin
                advance_trellis(sym_acc);
                sym_cnt++;
            end else begin
                cut_flag = 1'b1;
            end
            sym_acc = '0;
            bit_pos = 0;
        end else begin
            bit_pos = (bit_pos + 1) & 3;
        end
        if (it.frame_end) begin
            trace_frame();
            clear_frame();
        end
    endtask

    task automatic compare_word(t_result got);
        t_result want;
        if (expected_words.size() == 0) begin
            $display("%0t: unexpected result %p", $time, got);
            o_fail_count++;
            return;
        end
        want = expected_words.pop_front();
        if (got.decoded_word !== want.decoded_word) begin
            $display("%0t: decoded_word expected %h actual %h", $time,
                     want.decoded_word, got.decoded_word);
            o_fail_count++;
        end
        if (got.bit_count !== want.bit_count) begin
            $display("%0t: bit_count expected %0d actual %0d", $time,
                     want.bit_count, got.bit_count);
            o_fail_count++;
        end
        if (got.last_word !== want.last_word) begin
            $display("%0t: last_word expected %b actual %b", $time,
                     want.last_word, got.last_word);
            o_fail_count++;
        end
        if (got.best_metric !== want.best_metric) begin
            $display("%0t: best_metric expected %0d actual %0d", $time,
                     want.best_metric, got.best_metric);
            o_fail_count++;
        end
        if (got.truncated !== want.truncated) begin
            $display("%0t: truncated expected %b actual %b", $time,
                     want.truncated, got.truncated);
            o_fail_count++;
        end
    endtask

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_k = 3'd7;
            cfg_g = 3'd2;
            polys[0] = 7'h79;
            polys[1] = 7'h5B;
            polys[2] = '0;
            polys[3] = '0;
            clear_frame();
            expected_words.delete();
        end else begin
            // Results leave before a same-edge item can add new ones.
            if (i_valid) compare_word(i_result);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    C_REG_K:      cfg_k = i_cfg_data[2:0];
                    C_REG_G:      cfg_g = i_cfg_data[2:0];
                    C_REG_POLY_A: polys[0] = i_cfg_data;
                    C_REG_POLY_B: polys[1] = i_cfg_data;
                    C_REG_POLY_C: polys[2] = i_cfg_data;
                    C_REG_POLY_D: polys[3] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy) take_item(i_item);
        end
    end
endmodule

FILE: bench/viterbi_hard_decoder_core_tb.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the hard-decision Viterbi decoder. The checker
// beside the block mirrors its trellis and compares every result word.
module viterbi_hard_decoder_core_tb;
    import vhd_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     start;
    t_in_item item;
    logic     busy;
    logic     valid;
    t_result  result;
    logic     cfg_we;
    logic [2:0] cfg_idx;
    logic [6:0] cfg_data;
    int       fail_count;
    int       pending;

    viterbi_hard_decoder_core uut (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_item(item),
        .o_busy(busy), .o_valid(valid), .o_result(result),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    viterbi_hard_decoder_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_busy(busy),
        .i_item(item), .i_valid(valid), .i_result(result),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // The current code setting, used to shape well-formed frames.
    int cur_k;
    int cur_g;
    int items_sent;

    // Sends one item, with a random idle gap ahead of it. The start signal
    // stays high until the item is taken. Busy only changes after a rising
    // edge, so its value at a falling edge holds at the next rising edge.
    task automatic send_item(logic signed [7:0] sv, logic fe);
        int gap;
        gap = $urandom_range(0, 3);
        repeat (gap) @(negedge clk);
        start = 1'b1;
        item.soft_value = sv;
        item.frame_end = fe;
        while (busy) @(negedge clk);
        @(posedge clk);
        @(negedge clk);
        start = 1'b0;
        items_sent++;
    endtask

    // Writes one register between frames, once the decoder has gone quiet.
    // After the last expected word it may still be finishing a frame that
    // gives no words, so a guard wait that outlasts such a frame comes first.
    task automatic write_reg(logic [2:0] idx, logic [6:0] val);
        while (pending != 0) @(negedge clk);
        repeat (2600) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == C_REG_K) cur_k = val[2:0];
        if (idx == C_REG_G) cur_g = val[2:0];
    endtask

    task automatic set_code(int k, int g, logic [6:0] pa, logic [6:0] pb,
                            logic [6:0] pc, logic [6:0] pd);
        write_reg(C_REG_K, 7'(k));
        write_reg(C_REG_G, 7'(g));
        write_reg(C_REG_POLY_A, pa);
        write_reg(C_REG_POLY_B, pb);
        write_reg(C_REG_POLY_C, pc);
        write_reg(C_REG_POLY_D, pd);
    endtask

    function automatic logic signed [7:0] rand_soft();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0: return -8'sd128;
            1: return 8'sd127;
            2: return 8'sd0;
            3: return 8'sd1;
            4: return -8'sd1;
            default: return 8'($urandom);
        endcase
    endfunction

    // Sends a frame of the given number of symbols plus a few extra bits,
    // which leave a partial trailing symbol when not a multiple of g.
    task automatic send_frame(int nsym, int extra);
        int g, total;
        g = cur_g;
        if (g < 1) g = 1;
        if (g > C_MAX_GENERATORS) g = C_MAX_GENERATORS;
        total = nsym * g + extra;
        if (total < 1) total = 1;
        for (int i = 0; i < total; i++)
            send_item(rand_soft(), i == total - 1);
    endtask

    task automatic random_code();
        int k, g;
        k = $urandom_range(0, 7);
        g = $urandom_range(0, 7);
        set_code(k, g, 7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom));
    endtask

    initial begin
        int wait_cycles;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        cur_k = 7;
        cur_g = 2;
        items_sent = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: reset code, a one-item frame, a frame at exactly
        // the tail length (no words), and extreme soft values.
        send_item(-8'sd128, 1'b1);
        send_frame(6, 0);
        send_frame(8, 1);
        // Smallest trellis with one generator and all-zero taps.
        set_code(2, 1, 7'h00, 7'h7F, 7'h00, 7'h00);
        send_frame(4, 0);
        // Out-of-range settings: K below 2 and generator count 0 and 7.
        set_code(0, 0, 7'h03, 7'h01, 7'h02, 7'h01);
        send_frame(3, 0);
        set_code(1, 7, 7'h7F, 7'h55, 7'h2A, 7'h7F);
        send_frame(2, 3);

        // A store-overflowing frame at the cheapest setting sets truncated.
        set_code(2, 1, 7'h03, 7'h01, 7'h00, 7'h00);
        send_frame(C_MAX_SYMBOLS + 3, 0);

        // Random part: mostly small frames under random codes, with noise
        // frames that are often too short to decode.
        while (items_sent < 330 + C_MAX_SYMBOLS + 40) begin
            if ($urandom_range(0, 2) == 0) random_code();
            if ($urandom_range(0, 5) == 0) send_frame($urandom_range(0, 3), 0);
            else send_frame($urandom_range(cur_k, 20), $urandom_range(0, 3));
        end
        // One frame over 64 data bits at the default code.
        set_code(7, 2, 7'h79, 7'h5B, 7'h00, 7'h00);
        send_frame(140, 0);

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 200000) begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (3000) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("tb: failure");
        $finish;
    end
endmodule

FILE: viterbi_hard_decoder_core.f
design/vhd_pkg.sv
design/vhd_acs.sv
design/viterbi_hard_decoder_core.sv
bench/viterbi_hard_decoder_checker.sv
bench/viterbi_hard_decoder_core_tb.sv
